### hw/rtl/binary_to_decimal_ascii_formatter_core_assert.svh
// assertion macros for the formatter rtl, used by b2d_serializer
`ifndef BINARY_TO_DECIMAL_ASCII_FORMATTER_CORE_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_FORMATTER_CORE_ASSERT_SVH

// clocked assertion, disabled while reset is high
`define B2D_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define B2D_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/b2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2d_pkg
// types, opcodes and helpers for the binary to decimal ascii formatter
// ----------------------------------------------------------------------------
package b2d_pkg;

   // opcodes
   localparam logic [3:0] OP_DIGIT   = 4'd0;
   localparam logic [3:0] OP_COMMA   = 4'd1;
   localparam logic [3:0] OP_NEWLINE = 4'd2;
   localparam logic [3:0] OP_POINT   = 4'd3;
   localparam logic [3:0] OP_U16     = 4'd4;
   localparam logic [3:0] OP_S16     = 4'd5;
   localparam logic [3:0] OP_U32     = 4'd6;
   localparam logic [3:0] OP_VOLT    = 4'd7;
   localparam logic [3:0] OP_CURRENT = 4'd8;
   localparam logic [3:0] OP_POWER   = 4'd9;

   // ascii constants
   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_COMMA = 8'd44;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_POINT = 8'd46;
   localparam logic [7:0] CH_MINUS = 8'd45;
   localparam logic [7:0] CH_PLUS  = 8'd43;
   localparam logic [7:0] CH_V     = 8'h56;
   localparam logic [7:0] CH_M     = 8'h6d;
   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_W     = 8'h57;

   // conversion geometry
   localparam int BIN_W       = 32;
   localparam int BCD_DIGITS  = 10;
   localparam int BCD_W       = 4 * BCD_DIGITS;
   localparam int STEP_BITS   = 4;
   localparam int NUM_STAGES  = BIN_W / STEP_BITS;
   localparam int MAX_CHARS   = 12;

   typedef logic [MAX_CHARS-1:0][7:0] chars_type;

   // item moving through the conversion pipeline
   typedef struct packed {
      logic [3:0]       opcode;
      logic [7:0]       digit;
      logic             neg;
      logic [BCD_W-1:0] bcd;
      logic [BIN_W-1:0] bin;
   } dab_type;

   // one shift-add-3 step of the double dabble conversion
   function automatic dab_type dabble_step(input dab_type d);
      dab_type r;
      r = d;
      for (int k = 0; k < BCD_DIGITS; k++) begin
         if (r.bcd[4*k +: 4] >= 4'd5) begin
            r.bcd[4*k +: 4] = r.bcd[4*k +: 4] + 4'd3;
         end
      end
      {r.bcd, r.bin} = {r.bcd[BCD_W-2:0], r.bin, 1'b0};
      return r;
   endfunction

   // ascii code of a decimal digit
   function automatic logic [7:0] asc(input logic [3:0] d);
      return CH_ZERO + {4'd0, d};
   endfunction

endpackage

### hw/rtl/binary_to_decimal_ascii_formatter_core.sv
`timescale 1ns / 1ps
// an item passes the eight dabble stage registers, then the serializer register
// throughput: one item may enter every cycle unless stalled; output drains one
//   character a cycle when rsp_tready; an item has 0 to 12 characters by opcode
// the eight-stage double dabble pipeline stalls only while the output holds an item
// reset: synchronous, clears all valid bits and the serializer index and count; no data state
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_formatter_core
// formats opcode driven numbers and symbols into an ascii character stream
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_formatter_core #(
   parameter int LONG_DIGITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // opcode[3:0], digit[11:4], value[43:12], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // char_out[7:0]
   output logic        rsp_tlast
);
   import b2d_pkg::*;

   logic [3:0]  opcode;
   logic [7:0]  digit;
   logic [31:0] value;
   logic [15:0] low16;
   logic [16:0] mag;
   dab_type     head;

   logic    [NUM_STAGES:0] vld;
   logic    [NUM_STAGES:0] rdy;
   dab_type [NUM_STAGES:0] dat;

   chars_type  chars;
   logic [3:0] count;

   assign opcode = req_tdata[3:0];
   assign digit  = req_tdata[11:4];
   assign value  = req_tdata[43:12];
   assign low16  = value[15:0];
   assign mag    = 17'h10000 - {1'b0, low16};

   // number to convert: low half for u16, magnitude for s16, full value otherwise
   always_comb begin
      head.opcode = opcode;
      head.digit  = digit;
      head.neg    = 1'b0;
      head.bcd    = '0;
      head.bin    = value;
      case (opcode)
         OP_U16: head.bin = {16'd0, low16};
         OP_S16: begin
            head.neg = low16[15];
            head.bin = low16[15] ? {15'd0, mag} : {16'd0, low16};
         end
         default: head.bin = value;
      endcase
   end

   assign vld[0]     = req_tvalid;
   assign dat[0]     = head;
   assign req_tready = rdy[0];

   // conversion pipeline
   for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
      b2d_dabble_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vld[g]),
         .in_ready  (rdy[g]),
         .in_data   (dat[g]),
         .out_valid (vld[g+1]),
         .out_ready (rdy[g+1]),
         .out_data  (dat[g+1])
      );
   end

   b2d_format #(
      .LONG_DIGITS (LONG_DIGITS)
   ) u_format (
      .item  (dat[NUM_STAGES]),
      .chars (chars),
      .count (count)
   );

   b2d_serializer u_ser (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (vld[NUM_STAGES]),
      .in_ready   (rdy[NUM_STAGES]),
      .in_chars   (chars),
      .in_count   (count),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### hw/rtl/b2d_dabble_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2d_dabble_stage
// one register stage of the pipelined double dabble, STEP_BITS (4) bits per stage
// ----------------------------------------------------------------------------
module b2d_dabble_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  b2d_pkg::dab_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output b2d_pkg::dab_type out_data
);
   import b2d_pkg::*;

   logic    vld_ff, vld_in;
   dab_type dat_ff, dat_in;
   dab_type step_d;

   // shift in STEP_BITS bits of the binary word
   always_comb begin
      step_d = in_data;
      for (int s = 0; s < STEP_BITS; s++) begin
         step_d = dabble_step(step_d);
      end
   end

   assign in_ready = !vld_ff || out_ready;

   always_comb begin
      vld_in = vld_ff;
      dat_in = dat_ff;
      if (in_ready) begin
         vld_in = in_valid;
         dat_in = step_d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      dat_ff <= dat_in;
   end

   assign out_valid = vld_ff;
   assign out_data  = dat_ff;

endmodule

### hw/rtl/b2d_format.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2d_format
// lays out the ascii characters of one converted item and their count
// ----------------------------------------------------------------------------
module b2d_format #(
   parameter int LONG_DIGITS = 12
) (
   input  b2d_pkg::dab_type  item,
   output b2d_pkg::chars_type chars,
   output logic [3:0]        count
);
   import b2d_pkg::*;

   logic [4*MAX_CHARS-1:0] dg;

   assign dg = {{(4*MAX_CHARS-BCD_W){1'b0}}, item.bcd};

   // character layout by opcode
   always_comb begin
      chars = '0;
      count = 4'd0;
      case (item.opcode)
         OP_DIGIT: begin
            chars[0] = CH_ZERO + item.digit;
            count    = 4'd1;
         end
         OP_COMMA: begin
            chars[0] = CH_COMMA;
            count    = 4'd1;
         end
         OP_NEWLINE: begin
            chars[0] = CH_CR;
            chars[1] = CH_LF;
            count    = 4'd2;
         end
         OP_POINT: begin
            chars[0] = CH_POINT;
            count    = 4'd1;
         end
         OP_U16: begin
            if (item.bcd == '0) begin
               chars[0] = CH_ZERO;
               count    = 4'd1;
            end else begin
               for (int i = 0; i < 6; i++) begin
                  chars[i] = asc(dg[4*(5-i) +: 4]);
               end
               count = 4'd6;
            end
         end
         OP_S16: begin
            chars[0] = item.neg ? CH_MINUS : CH_PLUS;
            for (int i = 0; i < 6; i++) begin
               chars[i+1] = asc(dg[4*(5-i) +: 4]);
            end
            count = 4'd7;
         end
         OP_U32: begin
            for (int i = 0; i < LONG_DIGITS; i++) begin
               chars[i] = asc(dg[4*(LONG_DIGITS-1-i) +: 4]);
            end
            count = 4'(LONG_DIGITS);
         end
         OP_VOLT: begin
            chars[0] = asc(dg[12 +: 4]);
            chars[1] = asc(dg[8 +: 4]);
            chars[2] = CH_POINT;
            chars[3] = asc(dg[4 +: 4]);
            chars[4] = asc(dg[0 +: 4]);
            chars[5] = CH_V;
            count    = 4'd6;
         end
         OP_CURRENT: begin
            chars[0] = asc(dg[16 +: 4]);
            chars[1] = asc(dg[12 +: 4]);
            chars[2] = asc(dg[8 +: 4]);
            chars[3] = CH_POINT;
            chars[4] = asc(dg[4 +: 4]);
            chars[5] = CH_M;
            chars[6] = CH_A;
            count    = 4'd7;
         end
         OP_POWER: begin
            chars[0] = asc(dg[16 +: 4]);
            chars[1] = CH_POINT;
            chars[2] = asc(dg[12 +: 4]);
            chars[3] = asc(dg[8 +: 4]);
            chars[4] = asc(dg[4 +: 4]);
            chars[5] = CH_W;
            count    = 4'd6;
         end
         default: begin
            count = 4'd0;
         end
      endcase
   end

endmodule

### hw/rtl/b2d_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2d_serializer
// holds one formatted item and sends its characters one per transaction
// ----------------------------------------------------------------------------
module b2d_serializer (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  b2d_pkg::chars_type in_chars,
   input  logic [3:0]         in_count,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,
   output logic               rsp_tlast
);
   import b2d_pkg::*;
   `include "binary_to_decimal_ascii_formatter_core_assert.svh"

   logic       vld_ff, vld_in;
   logic [3:0] idx_ff, idx_in;
   logic [3:0] cnt_ff, cnt_in;
   chars_type  chr_ff, chr_in;
   logic       fire, done;

   assign fire      = vld_ff && rsp_tready;
   assign done      = fire && (idx_ff == cnt_ff - 4'd1);
   assign in_ready  = !vld_ff || done;

   // advance index, reload on a new item
   always_comb begin
      vld_in = vld_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      chr_in = chr_ff;
      if (fire) begin
         idx_in = idx_ff + 4'd1;
      end
      if (done) begin
         vld_in = 1'b0;
      end
      if (in_ready && in_valid && in_count != 4'd0) begin
         vld_in = 1'b1;
         idx_in = 4'd0;
         cnt_in = in_count;
         chr_in = in_chars;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         idx_ff <= 4'd0;
         cnt_ff <= 4'd0;
      end else begin
         vld_ff <= vld_in;
         idx_ff <= idx_in;
         cnt_ff <= cnt_in;
      end
      chr_ff <= chr_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = chr_ff[idx_ff];
   assign rsp_tlast  = (idx_ff == cnt_ff - 4'd1);

   // checks
   `B2D_ASSERT(a_idx_in_range, clock, reset, vld_ff |-> (idx_ff < cnt_ff), "index past count")
   `B2D_ASSERT(a_more_after_mid, clock, reset, (fire && !rsp_tlast) |=> vld_ff, "item cut short")
   `B2D_ASSERT_ALWAYS(a_idle_after_reset, clock, reset |=> !vld_ff, "valid after reset")

endmodule

### sim/binary_to_decimal_ascii_formatter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_formatter_core_tb
// self-checking bench for the decimal ascii formatter: a directed table of
// formatting commands, then random commands, each checked character by
// character against typed-in text or a behavioral formatter, with random stalls on both sides
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_formatter_core_tb;
   import b2d_pkg::*;

   localparam int LIMIT = 5000;
   localparam int N_RANDOM = 250;

   typedef struct {
      logic [3:0]  opcode;
      logic [7:0]  digit;
      logic [31:0] value;
      int          nchars;     // 0 when no typed-in answer
      logic [7:0]  text [12];
   } cmd_row_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } char_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;

   char_type    pending_chars [$];
   int          errors = 0;
   int          idle_cycles = 0;
   bit          quiet = 1'b0;     // no stalls in the closing part
   bit          hold_off = 1'b0;  // long receiver stall request

   binary_to_decimal_ascii_formatter_core dut (.*);

   always #5 clock = ~clock;

   // decimal digit k of v as ascii
   function automatic logic [7:0] dec_char(logic [31:0] v, int k);
      for (int i = 0; i < k; i++) v = v / 10;
      return CH_ZERO + 8'(v % 10);
   endfunction

   // queue the characters one command is expected to produce
   task automatic format_cmd(logic [3:0] op, logic [7:0] dg, logic [31:0] v);
      logic [7:0]  s [$];
      logic [15:0] lo;
      logic [16:0] mag;
      lo = v[15:0];
      case (op)
         OP_DIGIT:   s.push_back(dg + CH_ZERO);
         OP_COMMA:   s.push_back(CH_COMMA);
         OP_NEWLINE: begin s.push_back(CH_CR); s.push_back(CH_LF); end
         OP_POINT:   s.push_back(CH_POINT);
         OP_U16: begin
            if (lo == 0) s.push_back(CH_ZERO);
            else for (int k = 5; k >= 0; k--) s.push_back(dec_char({16'd0, lo}, k));
         end
         OP_S16: begin
            if (lo[15]) begin
               mag = 17'h10000 - {1'b0, lo};
               s.push_back(CH_MINUS);
            end else begin
               mag = {1'b0, lo};
               s.push_back(CH_PLUS);
            end
            for (int k = 5; k >= 0; k--) s.push_back(dec_char({15'd0, mag}, k));
         end
         OP_U32: for (int k = 11; k >= 0; k--) s.push_back(dec_char(v, k));
         OP_VOLT: begin
            s.push_back(dec_char(v, 3)); s.push_back(dec_char(v, 2));
            s.push_back(CH_POINT);
            s.push_back(dec_char(v, 1)); s.push_back(dec_char(v, 0));
            s.push_back(CH_V);
         end
         OP_CURRENT: begin
            s.push_back(dec_char(v, 4)); s.push_back(dec_char(v, 3));
            s.push_back(dec_char(v, 2)); s.push_back(CH_POINT);
            s.push_back(dec_char(v, 1)); s.push_back(CH_M); s.push_back(CH_A);
         end
         OP_POWER: begin
            s.push_back(dec_char(v, 4)); s.push_back(CH_POINT);
            s.push_back(dec_char(v, 3)); s.push_back(dec_char(v, 2));
            s.push_back(dec_char(v, 1)); s.push_back(CH_W);
         end
         default: ;
      endcase
      foreach (s[i]) pending_chars.push_back('{s[i], i == s.size() - 1});
   endtask

   // offer one transaction on the input channel, with optional gap first
   task automatic send_cmd(logic [3:0] op, logic [7:0] dg, logic [31:0] v);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, v, dg, op};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // receiver backpressure
   initial begin
      int n;
      @(negedge clock);
      while (1) begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (150) @(negedge clock);
            hold_off = 1'b0;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            n = $urandom_range(1, 7);
            repeat (n) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(5, 30)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // output checker and watchdog
   always @(posedge clock) begin
      char_type want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            if (pending_chars.size() == 0) begin
               $display("%0t: unexpected char %h last %b", $realtime, rsp_tdata, rsp_tlast);
               errors++;
            end else begin
               want = pending_chars.pop_front();
               if (want.ch !== rsp_tdata) begin
                  $display("%0t: char expected %h actual %h", $realtime, want.ch, rsp_tdata);
                  errors++;
               end
               if (want.last !== rsp_tlast) begin
                  $display("%0t: last expected %b actual %b", $realtime, want.last, rsp_tlast);
                  errors++;
               end
            end
         end
         if (idle_cycles >= LIMIT) begin
            $display("binary_to_decimal_ascii_formatter_core verification failed");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      cmd_row_type rows [$];
      cmd_row_type r;
      logic [3:0]  op;
      logic [7:0]  dg;
      logic [31:0] v;

      // directed table; nchars nonzero rows carry typed-in text
      rows = '{
         '{OP_DIGIT, 8'd0, 32'd0, 1, '{"0", 0,0,0,0,0,0,0,0,0,0,0}},
         '{OP_DIGIT, 8'd255, 32'hFFFF_FFFF, 1, '{8'd47, 0,0,0,0,0,0,0,0,0,0,0}},
         '{OP_DIGIT, 8'hAA, 32'd0, 0, '{default:0}},
         '{OP_DIGIT, 8'h55, 32'd0, 0, '{default:0}},
         '{OP_COMMA, 8'd0, 32'd0, 1, '{",", 0,0,0,0,0,0,0,0,0,0,0}},
         '{OP_NEWLINE, 8'd0, 32'd0, 2, '{8'd13, 8'd10, 0,0,0,0,0,0,0,0,0,0}},
         '{OP_POINT, 8'd0, 32'd0, 1, '{".", 0,0,0,0,0,0,0,0,0,0,0}},
         '{OP_U16, 8'd0, 32'hFFFF_0000, 1, '{"0", 0,0,0,0,0,0,0,0,0,0,0}},
         '{OP_U16, 8'd0, 32'h0000_FFFF, 6, '{"0","6","5","5","3","5",0,0,0,0,0,0}},
         '{OP_U16, 8'd0, 32'd1, 0, '{default:0}},
         '{OP_S16, 8'd0, 32'h0000_8000, 7, '{"-","0","3","2","7","6","8",0,0,0,0,0}},
         '{OP_S16, 8'd0, 32'h0000_7FFF, 7, '{"+","0","3","2","7","6","7",0,0,0,0,0}},
         '{OP_S16, 8'd0, 32'hFFFF_FFFF, 0, '{default:0}},
         '{OP_S16, 8'd0, 32'd0, 0, '{default:0}},
         '{OP_U32, 8'd0, 32'hFFFF_FFFF, 12,
           '{"0","0","4","2","9","4","9","6","7","2","9","5"}},
         '{OP_U32, 8'd0, 32'd0, 0, '{default:0}},
         '{OP_VOLT, 8'd0, 32'd1234, 6, '{"1","2",".","3","4","V",0,0,0,0,0,0}},
         '{OP_VOLT, 8'd0, 32'hFFFF_FFFF, 0, '{default:0}},
         '{OP_CURRENT, 8'd0, 32'd98765, 7, '{"9","8","7",".","6","m","A",0,0,0,0,0}},
         '{OP_CURRENT, 8'd0, 32'd0, 0, '{default:0}},
         '{OP_POWER, 8'd0, 32'd654321, 6, '{"5",".","4","3","2","W",0,0,0,0,0,0}},
         '{OP_POWER, 8'd0, 32'hFFFF_FFFF, 0, '{default:0}},
         '{4'd10, 8'd0, 32'd0, 0, '{default:0}},
         '{4'd15, 8'hFF, 32'hFFFF_FFFF, 0, '{default:0}}
      };

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         r = rows[i];
         if (r.nchars != 0) begin
            for (int k = 0; k < r.nchars; k++)
               pending_chars.push_back('{r.text[k], k == r.nchars - 1});
         end else begin
            format_cmd(r.opcode, r.digit, r.value);
         end
         send_cmd(r.opcode, r.digit, r.value);
      end

      // sender pause until everything has drained
      req_tvalid <= 1'b0;
      while (pending_chars.size() != 0) @(negedge clock);

      // receiver stalls long while commands keep coming
      hold_off = 1'b1;

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM - 40) quiet = 1'b1;
         op = (i % 23 == 7) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
         dg = 8'($urandom);
         case ($urandom_range(0, 4))
            0: v = $urandom_range(0, 9);
            1: v = $urandom_range(0, 99999);
            2: v = {16'($urandom), 1'b1, 15'($urandom)};
            default: v = $urandom;
         endcase
         format_cmd(op, dg, v);
         send_cmd(op, dg, v);
      end
      req_tvalid <= 1'b0;

      while (pending_chars.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
      if (errors == 0)
         $display("binary_to_decimal_ascii_formatter_core verification clean");
      else
         $display("binary_to_decimal_ascii_formatter_core verification failed");
      $finish;
   end

endmodule
